FILE: rtl/bdc_pkg.sv
// shared widths, limits and divider field codes for the baud divisor calculator
package bdc_pkg;

  localparam int unsigned BAUD_W    = 24;
  localparam int unsigned CLK_W     = 32;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned CODE_W    = 3;

  // largest denominator, one above the largest increment field value; the numerator may reach seven times this
  localparam int unsigned INC_LIMIT = 65535;

  // tolerance is (baud / TOL_DIV) * TOL_PCT
  localparam int unsigned TOL_DIV   = 100;
  localparam int unsigned TOL_PCT   = 3;

  // reference divider field codes
  localparam logic [CODE_W-1:0] CODE_DIV1   = 3'h5;
  localparam logic [CODE_W-1:0] CODE_DIV2   = 3'h4;
  localparam logic [CODE_W-1:0] CODE_DIV3   = 3'h3;
  localparam logic [CODE_W-1:0] CODE_DIV4   = 3'h2;
  localparam logic [CODE_W-1:0] CODE_DIV5   = 3'h1;
  localparam logic [CODE_W-1:0] CODE_DIV6   = 3'h0;
  localparam logic [CODE_W-1:0] CODE_DIV7   = 3'h6;
  localparam logic [CODE_W-1:0] CODE_UNUSED = 3'h7;

  // map a divider of 1..7 to its field code
  function automatic logic [CODE_W-1:0] div_code(input logic [CODE_W-1:0] divider);
    logic [CODE_W-1:0] code;
    unique case (divider)
      3'd1:    code = CODE_DIV1;
      3'd2:    code = CODE_DIV2;
      3'd3:    code = CODE_DIV3;
      3'd4:    code = CODE_DIV4;
      3'd5:    code = CODE_DIV5;
      3'd6:    code = CODE_DIV6;
      3'd7:    code = CODE_DIV7;
      default: code = CODE_DIV1;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/bdc_ifs.sv
// valid/ready channel interfaces for the request and the result transactions
interface bdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bdc_pkg::BAUD_W-1:0]    baud_rate;
  logic [bdc_pkg::CLK_W-1:0]     source_clock_hz;

  modport source (output valid, baud_rate, source_clock_hz, input ready);
  modport sink   (input valid, baud_rate, source_clock_hz, output ready);
endinterface

interface bdc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          within_tolerance;
  logic [bdc_pkg::CODE_W-1:0]    ref_div_code;
  logic [bdc_pkg::FIELD_W-1:0]   increment_value;
  logic [bdc_pkg::FIELD_W-1:0]   modulator_value;

  modport source (output valid, within_tolerance, ref_div_code, increment_value,
                  modulator_value, input ready);
  modport sink   (input valid, within_tolerance, ref_div_code, increment_value,
                  modulator_value, output ready);
endinterface

FILE: rtl/baud_divisor_calculator.sv
// Fractional UART baud divisor calculator built around one shared bit-serial divider.
// Each divide is issued, runs 48 shift steps and is handed back; a Euclid step adds a remainder state.
// How long a request runs depends on the gcd chains and on scaling; zero inputs go straight
// to the final state, which loads the output register once it is free.
// Throughput: one transaction at a time, set by the serial divider; a result held in
// the output register does not block the next request. Synchronous active-low reset.
module baud_divisor_calculator (
  input  logic      clk,
  input  logic      rst_n,
  bdc_in_if.sink    in_if,
  bdc_out_if.source out_if
);
  import bdc_pkg::*;

  localparam int unsigned DEN_W  = BAUD_W + 4;
  localparam int unsigned QW     = CLK_W + FIELD_W;
  localparam int unsigned CNT_W  = $clog2(QW + 1);
  localparam int unsigned BQ_W   = $clog2((1 << BAUD_W) / TOL_DIV + 1);
  localparam int unsigned TOL_W  = BQ_W + 2;

  localparam logic [CLK_W-1:0] LIM      = CLK_W'(INC_LIMIT);
  localparam logic [CLK_W-1:0] LIM7     = CLK_W'(7 * INC_LIMIT);
  localparam logic [CLK_W-1:0] TOL_DVS  = CLK_W'(TOL_DIV);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QW);

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_WAIT = 5'd1;
  localparam logic [4:0] ST_G1   = 5'd2;
  localparam logic [4:0] ST_G1R  = 5'd3;
  localparam logic [4:0] ST_NUM  = 5'd4;
  localparam logic [4:0] ST_DEN  = 5'd5;
  localparam logic [4:0] ST_CHK  = 5'd6;
  localparam logic [4:0] ST_M    = 5'd7;
  localparam logic [4:0] ST_N    = 5'd8;
  localparam logic [4:0] ST_SN   = 5'd9;
  localparam logic [4:0] ST_SD   = 5'd10;
  localparam logic [4:0] ST_DVR  = 5'd11;
  localparam logic [4:0] ST_G2   = 5'd12;
  localparam logic [4:0] ST_G2R  = 5'd13;
  localparam logic [4:0] ST_TN   = 5'd14;
  localparam logic [4:0] ST_TD   = 5'd15;
  localparam logic [4:0] ST_MUL  = 5'd16;
  localparam logic [4:0] ST_ACH  = 5'd17;
  localparam logic [4:0] ST_TOL  = 5'd18;
  localparam logic [4:0] ST_BQ   = 5'd19;
  localparam logic [4:0] ST_MD   = 5'd20;
  localparam logic [4:0] ST_FIN  = 5'd21;

  // control state
  logic [4:0]        state_r, state_nxt;
  logic [4:0]        ret_r, ret_nxt;
  logic [CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath registers
  logic [BAUD_W-1:0] baud_r, baud_nxt;
  logic [CLK_W-1:0]  sclk_r, sclk_nxt;
  logic              zero_r, zero_nxt;
  logic [CLK_W-1:0]  ga_r, ga_nxt;
  logic [CLK_W-1:0]  gb_r, gb_nxt;
  logic [CLK_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [CLK_W-1:0]  tmp_r, tmp_nxt;
  logic [CODE_W-1:0] divider_r, divider_nxt;
  logic [QW-1:0]     prod_r, prod_nxt;
  logic [TOL_W-1:0]  tol_r, tol_nxt;
  logic [FIELD_W-1:0] mod_r, mod_nxt;

  // shared divider registers: quotient/dividend shift, remainder, divisor
  logic [QW-1:0]     dq_r, dq_nxt;
  logic [CLK_W-1:0]  dr_r, dr_nxt;
  logic [CLK_W-1:0]  dd_r, dd_nxt;

  // output register
  logic              o_tol_r, o_tol_nxt;
  logic [CODE_W-1:0] o_code_r, o_code_nxt;
  logic [FIELD_W-1:0] o_inc_r, o_inc_nxt;
  logic [FIELD_W-1:0] o_mod_r, o_mod_nxt;

  // divide issue request
  logic              iss;
  logic [QW-1:0]     iss_dvd;
  logic [CLK_W-1:0]  iss_dvs;
  logic [4:0]        iss_ret;

  // one restoring divide step
  logic [CLK_W:0]    trial;
  logic [CLK_W:0]    trial_sub;
  logic              trial_ge;

  assign trial     = {dr_r, dq_r[QW-1]};
  assign trial_sub = trial - {1'b0, dd_r};
  assign trial_ge  = (trial >= {1'b0, dd_r});

  // helpers for the sequencer
  logic [CLK_W-1:0]  baud_x16;
  logic [CLK_W-1:0]  num_x16;
  logic [CLK_W-1:0]  q_plus1;
  logic [CLK_W-1:0]  mx;
  logic [QW-1:0]     mul_c;
  logic [QW-1:0]     ach_abs;
  logic [QW-1:0]     baud_ext;

  assign baud_x16 = CLK_W'({baud_r, 4'b0000});
  assign num_x16  = {num_r[CLK_W-5:0], 4'b0000};
  assign q_plus1  = dq_r[CLK_W-1:0] + CLK_W'(1);
  assign mx       = (tmp_r > q_plus1) ? tmp_r : q_plus1;
  assign mul_c    = QW'(tmp_r) * QW'(den_r[FIELD_W-1:0]);
  assign baud_ext = QW'(baud_r);
  assign ach_abs  = (prod_r >= baud_ext) ? (prod_r - baud_ext) : (baud_ext - prod_r);

  assign in_if.ready = (state_r == ST_IDLE);

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    baud_nxt      = baud_r;
    sclk_nxt      = sclk_r;
    zero_nxt      = zero_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    tmp_nxt       = tmp_r;
    divider_nxt   = divider_r;
    prod_nxt      = prod_r;
    tol_nxt       = tol_r;
    mod_nxt       = mod_r;
    dq_nxt        = dq_r;
    dr_nxt        = dr_r;
    dd_nxt        = dd_r;
    o_tol_nxt     = o_tol_r;
    o_code_nxt    = o_code_r;
    o_inc_nxt     = o_inc_r;
    o_mod_nxt     = o_mod_r;
    iss           = 1'b0;
    iss_dvd       = '0;
    iss_dvs       = CLK_W'(1);
    iss_ret       = ST_IDLE;

    // result leaves the output register
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          baud_nxt  = in_if.baud_rate;
          sclk_nxt  = in_if.source_clock_hz;
          zero_nxt  = (in_if.baud_rate == '0) || (in_if.source_clock_hz == '0);
          ga_nxt    = in_if.source_clock_hz;
          gb_nxt    = CLK_W'({in_if.baud_rate, 4'b0000});
          state_nxt = ((in_if.baud_rate == '0) || (in_if.source_clock_hz == '0)) ?
                      ST_FIN : ST_G1;
        end
      end
      ST_WAIT: begin
        if (dcnt_r != '0) begin
          dr_nxt   = trial_ge ? trial_sub[CLK_W-1:0] : trial[CLK_W-1:0];
          dq_nxt   = {dq_r[QW-2:0], trial_ge};
          dcnt_nxt = dcnt_r - CNT_W'(1);
        end else begin
          state_nxt = ret_r;
        end
      end
      // first gcd of clock and 16 * baud
      ST_G1: begin
        iss = 1'b1;
        if (gb_r == '0) begin
          iss_dvd = QW'(sclk_r);
          iss_dvs = ga_r;
          iss_ret = ST_NUM;
        end else begin
          iss_dvd = QW'(ga_r);
          iss_dvs = gb_r;
          iss_ret = ST_G1R;
        end
      end
      ST_G1R: begin
        ga_nxt    = gb_r;
        gb_nxt    = dr_r;
        state_nxt = ST_G1;
      end
      ST_NUM: begin
        num_nxt = dq_r[CLK_W-1:0];
        iss     = 1'b1;
        iss_dvd = QW'(baud_x16);
        iss_dvs = ga_r;
        iss_ret = ST_DEN;
      end
      ST_DEN: begin
        den_nxt   = dq_r[DEN_W-1:0];
        state_nxt = ST_CHK;
      end
      // scale down when a term is out of range, else go on to the reference divider
      ST_CHK: begin
        iss = 1'b1;
        if ((num_r > LIM7) || (CLK_W'(den_r) > LIM)) begin
          iss_dvd = QW'(num_r - CLK_W'(1));
          iss_dvs = LIM7;
          iss_ret = ST_M;
        end else begin
          iss_dvd = QW'(num_r - CLK_W'(1));
          iss_dvs = LIM;
          iss_ret = ST_DVR;
        end
      end
      ST_M: begin
        tmp_nxt = q_plus1;
        iss     = 1'b1;
        iss_dvd = QW'(CLK_W'(den_r) - CLK_W'(1));
        iss_dvs = LIM;
        iss_ret = ST_N;
      end
      ST_N: begin
        tmp_nxt = mx;
        iss     = 1'b1;
        iss_dvd = QW'(num_r);
        iss_dvs = mx;
        iss_ret = ST_SN;
      end
      ST_SN: begin
        num_nxt = (dq_r == '0) ? CLK_W'(1) : dq_r[CLK_W-1:0];
        iss     = 1'b1;
        iss_dvd = QW'(den_r);
        iss_dvs = tmp_r;
        iss_ret = ST_SD;
      end
      ST_SD: begin
        den_nxt = (dq_r == '0) ? DEN_W'(1) : dq_r[DEN_W-1:0];
        iss     = 1'b1;
        iss_dvd = QW'(num_r - CLK_W'(1));
        iss_dvs = LIM;
        iss_ret = ST_DVR;
      end
      // reference divider, then second gcd of clock and 16 * num
      ST_DVR: begin
        divider_nxt = dq_r[CODE_W-1:0] + CODE_W'(1);
        ga_nxt      = sclk_r;
        gb_nxt      = num_x16;
        state_nxt   = ST_G2;
      end
      ST_G2: begin
        iss = 1'b1;
        if (gb_r == '0) begin
          iss_dvd = QW'(sclk_r);
          iss_dvs = ga_r;
          iss_ret = ST_TN;
        end else begin
          iss_dvd = QW'(ga_r);
          iss_dvs = gb_r;
          iss_ret = ST_G2R;
        end
      end
      ST_G2R: begin
        ga_nxt    = gb_r;
        gb_nxt    = dr_r;
        state_nxt = ST_G2;
      end
      ST_TN: begin
        tmp_nxt = dq_r[CLK_W-1:0];
        iss     = 1'b1;
        iss_dvd = QW'(num_x16);
        iss_dvs = ga_r;
        iss_ret = ST_TD;
      end
      ST_TD: begin
        gb_nxt    = dq_r[CLK_W-1:0];
        state_nxt = ST_MUL;
      end
      // achieved rate = tnum * den / tden
      ST_MUL: begin
        prod_nxt  = mul_c;
        state_nxt = ST_ACH;
      end
      ST_ACH: begin
        iss     = 1'b1;
        iss_dvd = prod_r;
        iss_dvs = gb_r;
        iss_ret = ST_TOL;
      end
      ST_TOL: begin
        prod_nxt = dq_r;
        iss      = 1'b1;
        iss_dvd  = QW'(baud_r);
        iss_dvs  = TOL_DVS;
        iss_ret  = ST_BQ;
      end
      ST_BQ: begin
        tol_nxt = TOL_W'(dq_r[BQ_W-1:0]) * TOL_W'(TOL_PCT);
        iss     = 1'b1;
        iss_dvd = QW'(num_r);
        iss_dvs = CLK_W'(divider_r);
        iss_ret = ST_MD;
      end
      ST_MD: begin
        mod_nxt   = dq_r[FIELD_W-1:0] - FIELD_W'(1);
        state_nxt = ST_FIN;
      end
      // load the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            o_tol_nxt  = 1'b0;
            o_code_nxt = '0;
            o_inc_nxt  = '0;
            o_mod_nxt  = '0;
          end else begin
            o_tol_nxt  = (ach_abs < QW'(tol_r));
            o_code_nxt = div_code(divider_r);
            o_inc_nxt  = den_r[FIELD_W-1:0] - FIELD_W'(1);
            o_mod_nxt  = mod_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // start the shared divider
    if (iss) begin
      dq_nxt    = iss_dvd;
      dr_nxt    = '0;
      dd_nxt    = iss_dvs;
      dcnt_nxt  = DIV_STEPS;
      ret_nxt   = iss_ret;
      state_nxt = ST_WAIT;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    baud_r    <= baud_nxt;
    sclk_r    <= sclk_nxt;
    zero_r    <= zero_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    tmp_r     <= tmp_nxt;
    divider_r <= divider_nxt;
    prod_r    <= prod_nxt;
    tol_r     <= tol_nxt;
    mod_r     <= mod_nxt;
    dq_r      <= dq_nxt;
    dr_r      <= dr_nxt;
    dd_r      <= dd_nxt;
    o_tol_r   <= o_tol_nxt;
    o_code_r  <= o_code_nxt;
    o_inc_r   <= o_inc_nxt;
    o_mod_r   <= o_mod_nxt;
  end

  // result channel
  assign out_if.valid            = out_valid_r;
  assign out_if.within_tolerance = o_tol_r;
  assign out_if.ref_div_code     = o_code_r;
  assign out_if.increment_value  = o_inc_r;
  assign out_if.modulator_value  = o_mod_r;

endmodule

FILE: rtl/bdc_checker.sv
// port-level assertions for the baud divisor calculator and their bind
module bdc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         within_tolerance,
  input logic [bdc_pkg::CODE_W-1:0]   ref_div_code,
  input logic [bdc_pkg::FIELD_W-1:0]  increment_value,
  input logic [bdc_pkg::FIELD_W-1:0]  modulator_value
);
  import bdc_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(within_tolerance) &&
    $stable(ref_div_code) && $stable(increment_value) && $stable(modulator_value))
    else $error("stalled result changed");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a new result only comes out of a running computation
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

  // the divider field never carries the unused code
  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ref_div_code != CODE_UNUSED)
    else $error("illegal divider code");

endmodule

bind baud_divisor_calculator bdc_checker u_bdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .within_tolerance (out_if.within_tolerance),
  .ref_div_code     (out_if.ref_div_code),
  .increment_value  (out_if.increment_value),
  .modulator_value  (out_if.modulator_value)
);
